FILE: hdl/cds_pkg.sv
// ---------------------------------------------------------------------------
// cds_pkg - shared types and helpers for the calendar date stepper
// Item structs for both channels, action codes and month tables.
// ---------------------------------------------------------------------------
`default_nettype none

package cds_pkg;

  // action codes
  localparam logic [2:0] ACT_ADD_DAY   = 3'd0;
  localparam logic [2:0] ACT_ADD_MONTH = 3'd1;
  localparam logic [2:0] ACT_ADD_YEAR  = 3'd2;
  localparam logic [2:0] ACT_WEEKDAY   = 3'd3;
  localparam logic [2:0] ACT_NEXT_MON  = 3'd4;

  // month numbers
  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_APR = 4'd4;
  localparam logic [3:0] MONTH_JUN = 4'd6;
  localparam logic [3:0] MONTH_SEP = 4'd9;
  localparam logic [3:0] MONTH_NOV = 4'd11;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  // reciprocal of 100: floor(x / 100) == (x * 5243) >> 19 for x below 43699
  localparam int unsigned RECIP100_MUL   = 5243;
  localparam int unsigned RECIP100_SHIFT = 19;

  // year offset that keeps the zeller year positive, in whole 400-year cycles
  localparam logic [14:0] ZEL_YEAR_OFS = 15'd400;
  // -1 folded to +6 modulo 7
  localparam logic [10:0] ZEL_BIAS     = 11'd6;
  localparam logic [3:0]  WEEK_DAYS    = 4'd7;

  typedef struct packed {
    logic [2:0]  action;
    logic [13:0] in_year;
    logic [3:0]  in_month;
    logic [4:0]  in_day;
  } cds_in_t;

  typedef struct packed {
    logic [13:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [2:0]  weekday;
  } cds_out_t;

  // zeller month term floor(13 * (mm + 1) / 5), with months 0..2 taken as 12..14
  function automatic logic [5:0] zel_month_term(input logic [3:0] m);
    logic [5:0] r;
    unique case (m)
      4'd0:    r = 6'd33;
      4'd1:    r = 6'd36;
      4'd2:    r = 6'd39;
      4'd3:    r = 6'd10;
      4'd4:    r = 6'd13;
      4'd5:    r = 6'd15;
      4'd6:    r = 6'd18;
      4'd7:    r = 6'd20;
      4'd8:    r = 6'd23;
      4'd9:    r = 6'd26;
      4'd10:   r = 6'd28;
      4'd11:   r = 6'd31;
      4'd12:   r = 6'd33;
      4'd13:   r = 6'd36;
      4'd14:   r = 6'd39;
      default: r = 6'd41;
    endcase
    return r;
  endfunction

  // length of a month
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] r;
    if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV) begin
      r = 5'd30;
    end else if (m == MONTH_FEB) begin
      r = leap ? 5'd29 : 5'd28;
    end else begin
      r = 5'd31;
    end
    return r;
  endfunction

  // 100 * q by shift and add
  function automatic logic [14:0] times100(input logic [7:0] q);
    return (15'(q) << 6) + (15'(q) << 5) + (15'(q) << 2);
  endfunction

endpackage

`default_nettype wire

FILE: hdl/calendar_date_stepper_core.sv
// ---------------------------------------------------------------------------
// calendar_date_stepper_core - gregorian date stepper with weekday
// Steps a date by a day, a month, a year or to the next monday, and gives
// the weekday of the input date.
// ---------------------------------------------------------------------------
// Usage:
//   An item (action, year, month, day) is taken on a clock edge with start
//   high and busy low. busy is low whenever the block is out of reset, so a
//   new item may be given on every cycle.
//   Each item gives exactly one result on out_item, flagged by out_valid for
//   a single cycle; there is no back-pressure on the result side.
//   Throughput is one item per cycle, since every stage takes a new item on
//   each edge. There are five register stages (year prep, reciprocal multiply
//   by 100, remainders and zeller sum, modulo-7 fold and month lengths,
//   final date select).
//   The multiply stage holds three parallel constant multipliers, two 14x13
//   and one 15x13.
//   Items in flight at once never interact, so results come out in the
//   order the items went in.
//   Reset (rst_n low, synchronous) clears every stage valid bit, drops any
//   items in flight and holds busy high for as long as it lasts.
// ---------------------------------------------------------------------------
`default_nettype none

module calendar_date_stepper_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  output logic                 busy,
  input  wire cds_pkg::cds_in_t in_item,
  output logic                 out_valid,
  output cds_pkg::cds_out_t    out_item
);

  import cds_pkg::*;

  // ---------------- stage 1 : year prep ----------------
  logic        s1_vld_r;
  logic [2:0]  s1_act_r;
  logic [13:0] s1_y_r, s1_y1_r;
  logic [3:0]  s1_m_r;
  logic [4:0]  s1_d_r;
  logic [5:0]  s1_mt_r;
  logic [14:0] s1_yy_r;
  logic [14:0] s1_yy_nxt;

  // zeller year: shifted up a 400-year cycle, minus one for months up to february
  always_comb begin
    s1_yy_nxt = 15'(in_item.in_year) + ZEL_YEAR_OFS;
    if (in_item.in_month <= MONTH_FEB) begin
      s1_yy_nxt = s1_yy_nxt - 15'd1;
    end
  end

  assign busy = ~rst_n;

  // ---------------- stage 2 : divide by 100 ----------------
  logic        s2_vld_r;
  logic [2:0]  s2_act_r;
  logic [13:0] s2_y_r, s2_y1_r;
  logic [3:0]  s2_m_r;
  logic [4:0]  s2_d_r;
  logic [5:0]  s2_mt_r;
  logic [14:0] s2_yy_r;
  logic [7:0]  s2_qy_r, s2_qy1_r, s2_c_r;
  logic [27:0] s2_py_nxt, s2_py1_nxt, s2_pc_nxt;

  // reciprocal products
  always_comb begin
    s2_py_nxt  = 28'(s1_y_r)  * 28'(RECIP100_MUL);
    s2_py1_nxt = 28'(s1_y1_r) * 28'(RECIP100_MUL);
    s2_pc_nxt  = 28'(s1_yy_r) * 28'(RECIP100_MUL);
  end

  // ---------------- stage 3 : remainders, leap flags, zeller sum ----------------
  logic        s3_vld_r;
  logic [2:0]  s3_act_r;
  logic [13:0] s3_y_r, s3_y1_r;
  logic [3:0]  s3_m_r;
  logic [4:0]  s3_d_r;
  logic        s3_leap_y_r, s3_leap_y1_r;
  logic [10:0] s3_zsum_r;
  logic [14:0] ry_full, ry1_full, lo_full;
  logic [6:0]  ry, ry1, lo;
  logic        s3_leap_y_nxt, s3_leap_y1_nxt;
  logic [10:0] s3_zsum_nxt;

  always_comb begin
    ry_full  = 15'(s2_y_r)  - times100(s2_qy_r);
    ry1_full = 15'(s2_y1_r) - times100(s2_qy1_r);
    lo_full  = s2_yy_r      - times100(s2_c_r);
    ry  = ry_full[6:0];
    ry1 = ry1_full[6:0];
    lo  = lo_full[6:0];
    // gregorian rule: by 4 unless by 100, except by 400
    s3_leap_y_nxt  = (ry  != 7'd0) ? (s2_y_r[1:0]  == 2'd0) : (s2_qy_r[1:0]  == 2'd0);
    s3_leap_y1_nxt = (ry1 != 7'd0) ? (s2_y1_r[1:0] == 2'd0) : (s2_qy1_r[1:0] == 2'd0);
    // zeller sum, -2c taken as +5c
    s3_zsum_nxt = 11'(lo) + 11'(lo[6:2]) + 11'(s2_c_r[7:2])
                + (11'(s2_c_r) << 2) + 11'(s2_c_r)
                + 11'(s2_mt_r) + 11'(s2_d_r) + ZEL_BIAS;
  end

  // ---------------- stage 4 : modulo 7 and month lengths ----------------
  logic        s4_vld_r;
  logic [2:0]  s4_act_r;
  logic [13:0] s4_y_r, s4_y1_r;
  logic [3:0]  s4_m_r;
  logic [4:0]  s4_d_r;
  logic [2:0]  s4_wd_r;
  logic [4:0]  s4_len_cur_r, s4_len_mon_r, s4_len_yr_r;
  logic [4:0]  fold1;
  logic [3:0]  fold2;
  logic [3:0]  s4_mnext;
  logic [2:0]  s4_wd_nxt;

  always_comb begin
    // 8 == 1 modulo 7, so octal digits fold
    fold1 = 5'(s3_zsum_r[2:0]) + 5'(s3_zsum_r[5:3]) + 5'(s3_zsum_r[8:6])
          + 5'(s3_zsum_r[10:9]);
    fold2 = 4'(fold1[2:0]) + 4'(fold1[4:3]);
    s4_wd_nxt = (fold2 >= WEEK_DAYS) ? 3'(fold2 - WEEK_DAYS) : fold2[2:0];
    s4_mnext  = (s3_m_r < MONTH_DEC) ? s3_m_r + 4'd1 : MONTH_JAN;
  end

  // ---------------- stage 5 : final date ----------------
  logic        out_valid_r;
  cds_out_t    out_item_r;
  cds_out_t    out_item_nxt;
  logic        month_ok;
  logic [3:0]  step_n;
  logic [5:0]  day_sum;
  logic [13:0] y_res;
  logic [3:0]  m_res;
  logic [4:0]  d_res;

  always_comb begin
    month_ok = (s4_m_r >= MONTH_JAN) && (s4_m_r <= MONTH_DEC);
    // days to step: one, or up to the next monday
    if (s4_act_r == ACT_NEXT_MON && s4_wd_r != 3'd0) begin
      step_n = 4'd8 - 4'(s4_wd_r);
    end else begin
      step_n = 4'd1;
    end
    day_sum = 6'(s4_d_r) + 6'(step_n);
    y_res = s4_y_r;
    m_res = s4_m_r;
    d_res = s4_d_r;
    if (month_ok) begin
      unique case (s4_act_r)
        ACT_ADD_DAY, ACT_NEXT_MON: begin
          // a day past the month length stays put
          if (s4_d_r <= s4_len_cur_r) begin
            if (day_sum <= 6'(s4_len_cur_r)) begin
              d_res = day_sum[4:0];
            end else begin
              d_res = 5'(day_sum - 6'(s4_len_cur_r));
              if (s4_m_r < MONTH_DEC) begin
                m_res = s4_m_r + 4'd1;
              end else begin
                m_res = MONTH_JAN;
                y_res = s4_y1_r;
              end
            end
          end
        end
        ACT_ADD_MONTH: begin
          if (s4_m_r < MONTH_DEC) begin
            m_res = s4_m_r + 4'd1;
          end else begin
            m_res = MONTH_JAN;
            y_res = s4_y1_r;
          end
          if (s4_d_r > s4_len_mon_r) begin
            d_res = s4_len_mon_r;
          end
        end
        ACT_ADD_YEAR: begin
          y_res = s4_y1_r;
          if (s4_d_r > s4_len_yr_r) begin
            d_res = s4_len_yr_r;
          end
        end
        default: begin
        end
      endcase
    end
    out_item_nxt.out_year  = y_res;
    out_item_nxt.out_month = m_res;
    out_item_nxt.out_day   = d_res;
    out_item_nxt.weekday   = s4_wd_r;
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      s3_vld_r    <= 1'b0;
      s4_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_vld_r    <= start & ~busy;
      s2_vld_r    <= s1_vld_r;
      s3_vld_r    <= s2_vld_r;
      s4_vld_r    <= s3_vld_r;
      out_valid_r <= s4_vld_r;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    s1_act_r <= in_item.action;
    s1_y_r   <= in_item.in_year;
    s1_y1_r  <= in_item.in_year + 14'd1;
    s1_m_r   <= in_item.in_month;
    s1_d_r   <= in_item.in_day;
    s1_mt_r  <= zel_month_term(in_item.in_month);
    s1_yy_r  <= s1_yy_nxt;

    s2_act_r <= s1_act_r;
    s2_y_r   <= s1_y_r;
    s2_y1_r  <= s1_y1_r;
    s2_m_r   <= s1_m_r;
    s2_d_r   <= s1_d_r;
    s2_mt_r  <= s1_mt_r;
    s2_yy_r  <= s1_yy_r;
    s2_qy_r  <= s2_py_nxt[RECIP100_SHIFT +: 8];
    s2_qy1_r <= s2_py1_nxt[RECIP100_SHIFT +: 8];
    s2_c_r   <= s2_pc_nxt[RECIP100_SHIFT +: 8];

    s3_act_r     <= s2_act_r;
    s3_y_r       <= s2_y_r;
    s3_y1_r      <= s2_y1_r;
    s3_m_r       <= s2_m_r;
    s3_d_r       <= s2_d_r;
    s3_leap_y_r  <= s3_leap_y_nxt;
    s3_leap_y1_r <= s3_leap_y1_nxt;
    s3_zsum_r    <= s3_zsum_nxt;

    s4_act_r     <= s3_act_r;
    s4_y_r       <= s3_y_r;
    s4_y1_r      <= s3_y1_r;
    s4_m_r       <= s3_m_r;
    s4_d_r       <= s3_d_r;
    s4_wd_r      <= s4_wd_nxt;
    s4_len_cur_r <= month_len(s3_m_r, s3_leap_y_r);
    // december rolls to january, whose length needs no leap flag
    s4_len_mon_r <= month_len(s4_mnext, s3_leap_y_r);
    s4_len_yr_r  <= month_len(s3_m_r, s3_leap_y1_r);

    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // every item taken gives a result on out_valid
  a_lat_fwd : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##5 out_valid)
    else $error("item taken without a result five cycles later");

  // no result without a matching item taken before it
  a_lat_bwd : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 5))
    else $error("result without a matching item");

  // weekday stays in range
  a_wd_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.weekday < 3'd7))
    else $error("weekday out of range");

  // a weekday query leaves the date untouched
  a_query_pass : assert property (@(posedge clk) disable iff (!rst_n)
    (s4_vld_r && s4_act_r == ACT_WEEKDAY) |=>
      (out_item.out_year == $past(s4_y_r) && out_item.out_month == $past(s4_m_r)
       && out_item.out_day == $past(s4_d_r)))
    else $error("weekday query changed the date");

endmodule

`default_nettype wire

FILE: verif/tb_calendar_date_stepper_core.sv
// ---------------------------------------------------------------------------
// tb_calendar_date_stepper_core - self-checking bench for the date stepper
// Drives dated items with every action through the command port, works out
// the stepped date and the weekday of each accepted item, and compares each
// strobed result field by field against the oldest outstanding expectation.
// ---------------------------------------------------------------------------
module tb_calendar_date_stepper_core;

  import cds_pkg::*;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     start;
  logic     busy;
  cds_in_t  in_item;
  logic     out_valid;
  cds_out_t out_item;

  cds_out_t expected_dates[$];
  int       errors          = 0;
  int       items_sent      = 0;
  int       results_checked = 0;
  bit       gaps_enabled    = 1'b1;

  calendar_date_stepper_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  // free-running clock, period 2
  always #1 clk = ~clk;

  // gregorian month length
  function automatic logic [4:0] days_in_month(input logic [13:0] y, input logic [3:0] m);
    logic leap;
    leap = ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    case (m)
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: return 5'd30;
      MONTH_FEB: return leap ? 5'd29 : 5'd28;
      default:   return 5'd31;
    endcase
  endfunction

  // one calendar day forward; a day past month end or a bad month stays put
  function automatic void advance_day(inout logic [13:0] y, inout logic [3:0] m,
                                      inout logic [4:0] d);
    logic [4:0] len;
    if (m < MONTH_JAN || m > MONTH_DEC) return;
    len = days_in_month(y, m);
    if (d < len) begin
      d++;
    end else if (d == len) begin
      d = 5'd1;
      if (m < MONTH_DEC) begin
        m++;
      end else begin
        m = MONTH_JAN;
        y++;
      end
    end
  endfunction

  // stepped date plus zeller weekday of the input date
  function automatic cds_out_t next_date(input cds_in_t it);
    logic [13:0] y;
    logic [3:0]  m;
    logic [4:0]  d;
    logic [4:0]  len;
    int          zy, zm, cent, lo, wd, hops;
    cds_out_t    r;
    y = it.in_year;
    m = it.in_month;
    d = it.in_day;
    // zeller, with january and february taken as months 13 and 14
    zy = y + 400;
    zm = m;
    if (zm <= 2) begin
      zy--;
      zm += 12;
    end
    lo   = zy % 100;
    cent = zy / 100;
    wd   = (lo + lo / 4 + cent / 4 + 5 * cent + (13 * (zm + 1)) / 5 + d + 6) % 7;
    // date step, only for a real month
    if (m >= MONTH_JAN && m <= MONTH_DEC) begin
      case (it.action)
        ACT_ADD_DAY: advance_day(y, m, d);
        ACT_ADD_MONTH: begin
          if (m < MONTH_DEC) begin
            m++;
          end else begin
            m = MONTH_JAN;
            y++;
          end
          len = days_in_month(y, m);
          if (d > len) d = len;
        end
        ACT_ADD_YEAR: begin
          y++;
          len = days_in_month(y, m);
          if (d > len) d = len;
        end
        ACT_NEXT_MON: begin
          hops = (wd == 0) ? 1 : 8 - wd;
          for (int i = 0; i < hops; i++) advance_day(y, m, d);
        end
        default: ;
      endcase
    end
    r.out_year  = y;
    r.out_month = m;
    r.out_day   = d;
    r.weekday   = wd[2:0];
    return r;
  endfunction

  // present one item, hold it until taken, then maybe leave a gap with start low
  task automatic send_date(input logic [2:0] act, input logic [13:0] y,
                           input logic [3:0] m, input logic [4:0] d);
    cds_in_t it;
    it.action   = act;
    it.in_year  = y;
    it.in_month = m;
    it.in_day   = d;
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    expected_dates.push_back(next_date(it));
    items_sent++;
    if (gaps_enabled && $urandom_range(99) < 18) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // result checker: one strobed result against the oldest expectation
  always @(posedge clk) begin
    cds_out_t want;
    if (rst_n) begin
      if ($isunknown(out_valid)) begin
        $error("out_valid is unknown");
        errors++;
      end else if (out_valid) begin
        if (expected_dates.size() == 0) begin
          $error("result strobed with no item outstanding: %p", out_item);
          errors++;
        end else begin
          want = expected_dates.pop_front();
          results_checked++;
          if (out_item.out_year !== want.out_year) begin
            $error("out_year: expected %0d, got %0d", want.out_year, out_item.out_year);
            errors++;
          end
          if (out_item.out_month !== want.out_month) begin
            $error("out_month: expected %0d, got %0d", want.out_month, out_item.out_month);
            errors++;
          end
          if (out_item.out_day !== want.out_day) begin
            $error("out_day: expected %0d, got %0d", want.out_day, out_item.out_day);
            errors++;
          end
          if (out_item.weekday !== want.weekday) begin
            $error("weekday: expected %0d, got %0d", want.weekday, out_item.weekday);
            errors++;
          end
        end
      end
    end
  end

  // every action code on one ordinary date, spare codes included
  task automatic test_actions();
    for (int a = 0; a < 8; a++) send_date(3'(a), 14'd1583, 4'd10, 5'd15);
  endtask

  // month and year roll-overs, leap days and clamping
  task automatic test_calendar_edges();
    send_date(ACT_ADD_DAY,   14'd2023, MONTH_DEC, 5'd31);
    send_date(ACT_ADD_DAY,   14'd2024, MONTH_FEB, 5'd28);
    send_date(ACT_ADD_DAY,   14'd1900, MONTH_FEB, 5'd28);
    send_date(ACT_ADD_DAY,   14'd2000, MONTH_FEB, 5'd29);
    send_date(ACT_ADD_MONTH, 14'd2024, MONTH_JAN, 5'd31);
    send_date(ACT_ADD_YEAR,  14'd2024, MONTH_FEB, 5'd29);
    send_date(ACT_ADD_YEAR,  14'd9999, MONTH_DEC, 5'd31);
    send_date(ACT_NEXT_MON,  14'd2023, MONTH_DEC, 5'd31);
  endtask

  // malformed fields: year wrap, year zero, day zero, day past month end, bad month
  task automatic test_odd_fields();
    send_date(ACT_ADD_DAY,   14'd16383, MONTH_DEC, 5'd31);
    send_date(ACT_ADD_MONTH, 14'd16383, MONTH_DEC, 5'd15);
    send_date(ACT_WEEKDAY,   14'd0,     MONTH_JAN, 5'd1);
    send_date(ACT_ADD_DAY,   14'd2024,  MONTH_APR, 5'd31);
    send_date(ACT_ADD_MONTH, 14'd2024,  MONTH_APR, 5'd31);
    send_date(ACT_ADD_DAY,   14'd2024,  4'd5,      5'd0);
    send_date(ACT_ADD_MONTH, 14'd2024,  4'd5,      5'd0);
    send_date(ACT_NEXT_MON,  14'd2024,  4'd0,      5'd17);
    send_date(ACT_ADD_DAY,   14'd2024,  4'd13,     5'd9);
    send_date(ACT_ADD_YEAR,  14'd16383, 4'd15,     5'd31);
  endtask

  // mostly well-formed dates, many near month ends, the rest raw bit noise
  task automatic test_random(input int count);
    cds_in_t     noise;
    logic [13:0] y;
    logic [3:0]  m;
    logic [4:0]  d;
    logic [4:0]  len;
    logic [2:0]  act;
    int          pick;
    for (int i = 0; i < count; i++) begin
      // a long stretch with back-to-back items
      gaps_enabled = !(i >= 200 && i < 400);
      if ($urandom_range(99) < 80) begin
        pick = $urandom_range(99);
        if (pick < 80)      y = 14'($urandom_range(1583, 9999));
        else if (pick < 90) y = 14'($urandom_range(16370, 16383));
        else                y = 14'($urandom_range(0, 1600));
        m   = 4'($urandom_range(1, 12));
        len = days_in_month(y, m);
        pick = $urandom_range(99);
        if (pick < 10)      d = 5'($urandom_range(0, 31));
        else if (pick < 40) d = len - 5'($urandom_range(0, 2));
        else                d = 5'($urandom_range(1, len));
        act = ($urandom_range(99) < 95) ? 3'($urandom_range(0, 4)) : 3'($urandom_range(5, 7));
        send_date(act, y, m, d);
      end else begin
        noise = cds_in_t'(26'($urandom));
        send_date(noise.action, noise.in_year, noise.in_month, noise.in_day);
      end
    end
    gaps_enabled = 1'b1;
  endtask

  // main sequence
  initial begin
    int waited;
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_item <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_actions();
    test_calendar_edges();
    test_odd_fields();
    test_random(650);
    start <= 1'b0;

    // drain the pipeline
    waited = 0;
    while (expected_dates.size() != 0 && waited < 200) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (expected_dates.size() != 0) begin
      $error("%0d results never arrived", expected_dates.size());
      errors++;
    end

    $display("%0d items sent, %0d results checked, %0d mismatches", items_sent,
             results_checked, errors);
    $display("covered all action codes, leap days, month and year roll-over, year wrap,");
    $display("day zero, days past month end, bad months and raw field noise");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #400000;
    $display("FAIL");
    $finish;
  end

endmodule
